@@ hw/rtl/assert_macros.svh @@
// Assertion helpers; they compile away when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define IPBL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ipbl assertion failed");

`define IPBL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ipbl implication failed");

`else

`define IPBL_ASSERT(lbl, prop)

`define IPBL_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/ipbl_pkg.sv @@
`default_nettype none

package ipbl_pkg;

  localparam int MaxEntries  = 32;
  localparam int IdxW        = $clog2(MaxEntries);
  localparam int CntW        = $clog2(MaxEntries + 1);
  localparam int EntryCountW = 6;
  localparam int AddrW       = 32;
  localparam int VerW        = 4;
  localparam int QueueDepth  = 2;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCntW       = $clog2(QueueDepth + 1);

  localparam logic [VerW-1:0] IpVersion4 = 4'd4;

  typedef enum logic [1:0] {
    ReqCheck = 2'd0,
    ReqAdd   = 2'd1,
    ReqDel   = 2'd2,
    ReqClear = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNotFound = 2'd2,
    StPresent  = 2'd3
  } status_e;

  typedef struct packed {
    req_type_e        req_type;
    logic [VerW-1:0]  ip_version;
    logic [AddrW-1:0] address;
  } req_t;

  typedef struct packed {
    logic                   drop;
    status_e                status;
    logic [EntryCountW-1:0] entry_count;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/ipbl_in_queue.sv @@
`default_nettype none

// Front end: takes requests and holds them until the engine pulls one.
module ipbl_in_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire ipbl_pkg::req_t req_i,
  output logic                q_valid_o,
  input  wire                 q_ready_i,
  output ipbl_pkg::req_t      q_req_o
);

  ipbl_pkg::req_t                   mem_q [ipbl_pkg::QueueDepth];
  logic [ipbl_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ipbl_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ipbl_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                             push, pop;

  assign in_ready_o = (cnt_q != ipbl_pkg::QCntW'(ipbl_pkg::QueueDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_req_o    = mem_q[rd_ptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == ipbl_pkg::QPtrW'(ipbl_pkg::QueueDepth - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == ipbl_pkg::QPtrW'(ipbl_pkg::QueueDepth - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ipbl_engine.sv @@
`default_nettype none

// Back end: table of blocked addresses, parallel compare, update, result register.
module ipbl_engine (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_valid_i,
  output logic                q_ready_o,
  input  wire ipbl_pkg::req_t q_req_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ipbl_pkg::res_t      res_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StCmp  = 3'b010,
    StExe  = 3'b100
  } state_e;

  state_e                           state_q, state_d;
  ipbl_pkg::req_t                   cur_q;
  logic [ipbl_pkg::AddrW-1:0]       table_q [ipbl_pkg::MaxEntries];
  logic [ipbl_pkg::MaxEntries-1:0]  hit, match_q, at_or_after;
  logic [ipbl_pkg::CntW-1:0]        count_q, count_d;
  ipbl_pkg::res_t                   res_q, res_d;
  logic                             res_valid_q;
  logic                             exe_done, pop;
  logic                             found, full;
  logic                             add_we, del_we;

  assign exe_done  = (state_q == StExe) & (!res_valid_q | out_ready_i);
  assign q_ready_o = (state_q == StIdle) | exe_done;
  assign pop       = q_valid_i & q_ready_o;

  assign out_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (pop) state_d = StCmp;
      StCmp:   state_d = StExe;
      StExe: begin
        if (pop) begin
          state_d = StCmp;
        end else if (exe_done) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // compare against every live entry in parallel
  for (genvar g = 0; g < ipbl_pkg::MaxEntries; g++) begin : g_cmp
    assign hit[g] = (ipbl_pkg::CntW'(g) < count_q) && (table_q[g] == cur_q.address);
    // entries at or past the deleted slot move down by one
    assign at_or_after[g] = |match_q[g:0];
  end

  assign found = |match_q;
  assign full  = (count_q >= ipbl_pkg::CntW'(ipbl_pkg::MaxEntries));

  always_comb begin
    add_we          = 1'b0;
    del_we          = 1'b0;
    count_d         = count_q;
    res_d.drop      = 1'b0;
    res_d.status    = ipbl_pkg::StOk;
    case (cur_q.req_type)
      ipbl_pkg::ReqCheck: begin
        res_d.drop = found & (cur_q.ip_version == ipbl_pkg::IpVersion4);
      end
      ipbl_pkg::ReqAdd: begin
        if (full) begin
          res_d.status = ipbl_pkg::StFull;
        end else if (found) begin
          res_d.status = ipbl_pkg::StPresent;
        end else begin
          add_we  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ipbl_pkg::ReqDel: begin
        if (!found) begin
          res_d.status = ipbl_pkg::StNotFound;
        end else begin
          del_we  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      ipbl_pkg::ReqClear: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    res_d.entry_count = ipbl_pkg::EntryCountW'(count_d);
  end

  for (genvar g = 0; g < ipbl_pkg::MaxEntries; g++) begin : g_tbl
    logic [ipbl_pkg::AddrW-1:0] next_entry;
    if (g < ipbl_pkg::MaxEntries - 1) begin : g_nb
      assign next_entry = table_q[g+1];
    end else begin : g_last
      assign next_entry = table_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (exe_done) begin
        if (add_we && (count_q[ipbl_pkg::IdxW-1:0] == ipbl_pkg::IdxW'(g))) begin
          table_q[g] <= cur_q.address;
        end else if (del_we && at_or_after[g]) begin
          table_q[g] <= next_entry;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exe_done) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= q_req_i;
    end
    if (state_q == StCmp) begin
      match_q <= hit;
    end
    if (exe_done) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ipv4_destination_blocklist_unit.sv @@
`default_nettype none

// Channel   Handshake                 Payload
// request   in_valid_i / in_ready_o   req_type_i, ip_version_i, address_i
// result    out_valid_o / out_ready_i drop_o, status_o, entry_count_o
//
// Each request passes through the engine's compare step (parallel over all
// table entries) and then its update step (update the table, load the result register).
// A 2-deep request queue sits in front, so requests are taken while the
// engine works or while a result waits. Reset empties the table (count 0),
// the request queue and the result register at once; no clearing pass.
// A stalled result holds the engine in its update step; the queue fills up.
module ipv4_destination_blocklist_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  req_type_i,
  input  wire  [3:0]  ip_version_i,
  input  wire  [31:0] address_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        drop_o,
  output logic [1:0]  status_o,
  output logic [5:0]  entry_count_o
);

  `include "assert_macros.svh"

  ipbl_pkg::req_t in_req, q_req;
  ipbl_pkg::res_t res;
  logic           q_valid, q_ready;

  assign in_req.req_type   = ipbl_pkg::req_type_e'(req_type_i);
  assign in_req.ip_version = ip_version_i;
  assign in_req.address    = address_i;

  ipbl_in_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_i      (in_req),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_req_o    (q_req)
  );

  ipbl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_req_i     (q_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign drop_o        = res.drop;
  assign status_o      = res.status;
  assign entry_count_o = res.entry_count;

  `IPBL_ASSERT_IMPL(a_count_max, out_valid_o, entry_count_o <= 6'(ipbl_pkg::MaxEntries))
  `IPBL_ASSERT_IMPL(a_drop_ok, out_valid_o && drop_o, status_o == ipbl_pkg::StOk)
  `IPBL_ASSERT_IMPL(a_full_count, out_valid_o && status_o == ipbl_pkg::StFull,
                    entry_count_o == 6'(ipbl_pkg::MaxEntries))
  `IPBL_ASSERT_IMPL(a_empty_nodrop, out_valid_o && entry_count_o == 6'd0, !drop_o)

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;
  import ipbl_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomRequests = 600;
  localparam int PoolSize = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [1:0]  req_type_i = ReqCheck;
  logic [3:0]  ip_version_i = 4'd0;
  logic [31:0] address_i = 32'd0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        drop_o;
  logic [1:0]  status_o;
  logic [5:0]  entry_count_o;

  ipv4_destination_blocklist_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .ip_version_i (ip_version_i),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drop_o       (drop_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  typedef struct {
    req_type_e   req;
    logic [3:0]  ver;
    logic [31:0] addr;
    bit          typed;
    res_t        verdict;
  } vector_t;

  // shadow of the blocked table, in insertion order
  logic [31:0] blocked_addr [MaxEntries];
  int          blocked_n = 0;
  logic [31:0] addr_pool [PoolSize];

  res_t        pending_verdicts [$];
  vector_t     directed_rows [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_verdicts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic res_t blocklist_apply(req_type_e req, logic [3:0] ver,
                                           logic [31:0] addr);
    res_t r;
    int   hit;
    r.drop = 1'b0;
    r.status = StOk;
    hit = -1;
    for (int k = 0; k < blocked_n; k++) begin
      if (hit < 0 && blocked_addr[k] == addr) hit = k;
    end
    case (req)
      ReqCheck: begin
        if (ver == IpVersion4 && hit >= 0) r.drop = 1'b1;
      end
      ReqAdd: begin
        // full wins over duplicate
        if (blocked_n >= MaxEntries) begin
          r.status = StFull;
        end else if (hit >= 0) begin
          r.status = StPresent;
        end else begin
          blocked_addr[blocked_n] = addr;
          blocked_n++;
        end
      end
      ReqDel: begin
        if (hit < 0) begin
          r.status = StNotFound;
        end else begin
          for (int k = hit; k + 1 < blocked_n; k++) blocked_addr[k] = blocked_addr[k + 1];
          blocked_n--;
        end
      end
      default: blocked_n = 0;
    endcase
    r.entry_count = blocked_n[5:0];
    return r;
  endfunction

  function automatic vector_t row(req_type_e req, logic [3:0] ver, logic [31:0] addr,
                                  bit typed = 1'b0, logic drop = 1'b0,
                                  status_e st = StOk, logic [5:0] cnt = 6'd0);
    vector_t v;
    v.req = req;
    v.ver = ver;
    v.addr = addr;
    v.typed = typed;
    v.verdict.drop = drop;
    v.verdict.status = st;
    v.verdict.entry_count = cnt;
    return v;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("[%0d] result %s: got %0d, expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // valid stays high across back-to-back requests; it only drops for a gap
  task automatic offer_request(req_type_e req, logic [3:0] ver, logic [31:0] addr,
                               bit typed, res_t typed_verdict);
    int   gap;
    res_t verdict;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    ip_version_i <= ver;
    address_i <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    verdict = blocklist_apply(req, ver, addr);
    pending_verdicts.push_back(typed ? typed_verdict : verdict);
  endtask

  // mode 0: mixed traffic, 1: fill the table, 2: drain it
  task automatic random_request(int mode);
    int          pick;
    req_type_e   req;
    logic [3:0]  ver;
    logic [31:0] addr;
    res_t        unused;
    pick = $urandom_range(0, 99);
    case (mode)
      1: req = (pick < 75) ? ReqAdd : (pick < 95) ? ReqCheck : ReqDel;
      2: req = (pick < 60) ? ReqDel : (pick < 90) ? ReqCheck : ReqAdd;
      default: req = (pick < 40) ? ReqCheck : (pick < 72) ? ReqAdd :
                     (pick < 97) ? ReqDel : ReqClear;
    endcase
    ver = ($urandom_range(0, 9) < 7) ? IpVersion4 : 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      addr = $urandom;
    end else if (pick < 55 && blocked_n > 0 && req != ReqAdd) begin
      addr = blocked_addr[$urandom_range(0, blocked_n - 1)];
    end else begin
      addr = addr_pool[$urandom_range(0, PoolSize - 1)];
    end
    unused = '0;
    offer_request(req, ver, addr, 1'b0, unused);
  endtask

  // result side
  initial begin
    int   stall;
    res_t want;
    wait (rst_ni);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_verdicts.size() == 0) begin
        flag_mismatch("with none pending, entry_count", entry_count_o, -1);
      end else begin
        want = pending_verdicts.pop_front();
        if (drop_o !== want.drop) flag_mismatch("drop", drop_o, want.drop);
        if (status_o !== want.status) flag_mismatch("status", status_o, want.status);
        if (entry_count_o !== want.entry_count) begin
          flag_mismatch("entry_count", entry_count_o, want.entry_count);
        end
      end
    end
  end

  // request side
  initial begin
    int  sent;
    int  span;
    int  mode;
    bit  paused;
    for (int k = 0; k < PoolSize; k++) addr_pool[k] = $urandom;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;

    directed_rows.push_back(row(ReqCheck, 4'd4,  32'h0000_0000, 1, 0, StOk, 0));
    directed_rows.push_back(row(ReqDel,   4'd4,  32'h0000_0000, 1, 0, StNotFound, 0));
    directed_rows.push_back(row(ReqAdd,   4'd0,  32'h0000_0000, 1, 0, StOk, 1));
    directed_rows.push_back(row(ReqAdd,   4'd15, 32'hFFFF_FFFF, 1, 0, StOk, 2));
    directed_rows.push_back(row(ReqAdd,   4'd4,  32'h0000_0000, 1, 0, StPresent, 2));
    directed_rows.push_back(row(ReqCheck, 4'd4,  32'hFFFF_FFFF, 1, 1, StOk, 2));
    directed_rows.push_back(row(ReqCheck, 4'd15, 32'hFFFF_FFFF, 1, 0, StOk, 2));
    directed_rows.push_back(row(ReqCheck, 4'd0,  32'h0000_0000, 1, 0, StOk, 2));
    directed_rows.push_back(row(ReqCheck, 4'd4,  32'h0000_0000, 1, 1, StOk, 2));
    directed_rows.push_back(row(ReqCheck, 4'd4,  32'h0A00_0001));
    directed_rows.push_back(row(ReqAdd,   4'd6,  32'h0A00_0001));
    directed_rows.push_back(row(ReqAdd,   4'd4,  32'hC0A8_0101));
    directed_rows.push_back(row(ReqDel,   4'd4,  32'hFFFF_FFFF));
    directed_rows.push_back(row(ReqCheck, 4'd4,  32'hC0A8_0101));
    directed_rows.push_back(row(ReqDel,   4'd9,  32'hFFFF_FFFF));
    directed_rows.push_back(row(ReqCheck, 4'd6,  32'h0A00_0001));
    directed_rows.push_back(row(ReqCheck, 4'd5,  32'h0A00_0001));
    directed_rows.push_back(row(ReqClear, 4'd15, 32'hFFFF_FFFF, 1, 0, StOk, 0));
    directed_rows.push_back(row(ReqCheck, 4'd4,  32'h0000_0000, 1, 0, StOk, 0));
    directed_rows.push_back(row(ReqClear, 4'd0,  32'h0000_0000, 1, 0, StOk, 0));
    directed_rows.push_back(row(ReqDel,   4'd4,  32'hFFFF_FFFF, 1, 0, StNotFound, 0));
    directed_rows.push_back(row(ReqAdd,   4'd4,  32'hFFFF_FFFF, 1, 0, StOk, 1));
    directed_rows.push_back(row(ReqCheck, 4'd11, 32'hFFFF_FFFF));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req, directed_rows[i].ver, directed_rows[i].addr,
                    directed_rows[i].typed, directed_rows[i].verdict);
    end

    // random traffic in episodes; the first one runs in fill mode and pushes the table toward full
    sent = 0;
    paused = 1'b0;
    mode = 1;
    span = 45;
    while (sent < RandomRequests) begin
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < span && sent < RandomRequests; k++) begin
        random_request(mode);
        sent++;
        if (!paused && sent >= RandomRequests / 2) begin
          paused = 1'b1;
          in_valid_i <= 1'b0;
          while (pending_verdicts.size() != 0) @(posedge clk_i);
        end
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 40);
    end
    in_valid_i <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
